// ===== hdl/mkd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared widths, constants and types of the Morse key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

	localparam int UnitW    = 16;
	localparam int CountW   = 19;
	localparam int PatW     = 7;
	localparam int DahMult  = 3;
	localparam int WordMult = 7;
	localparam int UnitReset = 100;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [CountW-1:0] CountMax      = {CountW{1'b1}};
	localparam logic [CountW-1:0] DahLimitReset = CountW'(DahMult * UnitReset);
	localparam logic [CountW-1:0] WordLimitReset = CountW'(WordMult * UnitReset);
	localparam logic [PatW-1:0]   PatStart      = PatW'(1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DOWN = 2'd1,
		PH_UP   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [PatW-1:0] symbol_index;
		logic            overflow;
		logic            word_last;
	} sym_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

// ===== hdl/mkd_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder channel interfaces
// Valid/ready channels for key samples and decoded symbols.
// ----------------------------------------------------------------------------
interface mkd_sample_if;
	logic valid;
	logic ready;
	logic key_down;

	modport source (output valid, output key_down, input ready);
	modport sink (input valid, input key_down, output ready);
endinterface

interface mkd_symbol_if import mkd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PatW-1:0] symbol_index;
	logic            overflow;
	logic            word_last;

	modport source (output valid, output symbol_index, output overflow, output word_last,
		input ready);
	modport sink (input valid, input symbol_index, input overflow, input word_last,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/mkd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder front end
// Accepts key samples, times presses and gaps, builds the pattern index and
// pushes finished letters into the result queue.
// ----------------------------------------------------------------------------
module mkd_front import mkd_pkg::*; #(
	parameter int MAX_ELEMENTS = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [UnitW-1:0] cfg_data,
	mkd_sample_if.sink            sample,
	input  wire logic             q_full,
	output logic                  push,
	output sym_t                  push_data
);

	localparam logic [PatW-1:0] PatLimit = PatW'(1 << MAX_ELEMENTS);

	phase_t            phase_q, phase_d;
	logic [CountW-1:0] cnt_q, cnt_d, cnt_inc;
	logic [PatW-1:0]   pat_q, pat_d;
	logic              long_q, long_d;
	logic [CountW-1:0] dah_lim_q, word_lim_q;
	logic              acc;

	assign sample.ready = !q_full;
	assign acc = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dah_lim_q  <= DahLimitReset;
			word_lim_q <= WordLimitReset;
		end else if (cfg_we) begin
			dah_lim_q  <= (CountW'(cfg_data) << 1) + CountW'(cfg_data);
			word_lim_q <= (CountW'(cfg_data) << 3) - CountW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			pat_q   <= PatStart;
			long_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			pat_q   <= pat_d;
			long_q  <= long_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		pat_d     = pat_q;
		long_d    = long_q;
		push      = 1'b0;
		cnt_inc   = (cnt_q == CountMax) ? cnt_q : cnt_q + CountW'(1);
		push_data = '{symbol_index: pat_q, overflow: long_q, word_last: 1'b0};
		if (acc) begin
			case (phase_q)
				PH_DOWN: begin
					if (sample.key_down) begin
						cnt_d = cnt_inc;
					end else begin
						if (pat_q >= PatLimit) begin
							long_d = 1'b1;
						end else begin
							pat_d = {pat_q[PatW-2:0], cnt_q > dah_lim_q};
						end
						phase_d = PH_UP;
						cnt_d   = CountW'(1);
					end
				end
				PH_UP: begin
					if (!sample.key_down) begin
						if (cnt_inc > word_lim_q) begin
							push                = 1'b1;
							push_data.word_last = 1'b1;
							phase_d             = PH_IDLE;
							cnt_d               = '0;
							pat_d               = PatStart;
							long_d              = 1'b0;
						end else begin
							cnt_d = cnt_inc;
						end
					end else if (cnt_q > dah_lim_q) begin
						push    = 1'b1;
						phase_d = PH_DOWN;
						cnt_d   = CountW'(1);
						pat_d   = PatStart;
						long_d  = 1'b0;
					end else begin
						phase_d = PH_DOWN;
						cnt_d   = CountW'(1);
					end
				end
				default: begin
					if (sample.key_down) begin
						phase_d = PH_DOWN;
						cnt_d   = CountW'(1);
						pat_d   = PatStart;
						long_d  = 1'b0;
					end else begin
						phase_d = PH_IDLE;
						cnt_d   = '0;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mkd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder result queue
// Short first-in first-out queue between the front end and the output stage.
// ----------------------------------------------------------------------------
module mkd_queue import mkd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire sym_t push_data,
	input  wire logic pop,
	output sym_t      pop_data,
	output queue_status_t status
);

	sym_t                 mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 do_push, do_pop;

	assign status.full  = (cnt_q == QueueCntW'(QueueDepth));
	assign status.empty = (cnt_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
					: wr_ptr_q + QueuePtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
					: rd_ptr_q + QueuePtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QueueCntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QueueCntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mkd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder output stage
// Drains the result queue into a registered symbol channel.
// ----------------------------------------------------------------------------
module mkd_back import mkd_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire queue_status_t q_status,
	input  wire sym_t          q_data,
	output logic               pop,
	mkd_symbol_if.source       symbol
);

	logic valid_q;
	sym_t data_q;

	assign pop = !q_status.empty && (!valid_q || symbol.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || symbol.ready) begin
			valid_q <= !q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

	assign symbol.valid        = valid_q;
	assign symbol.symbol_index = data_q.symbol_index;
	assign symbol.overflow     = data_q.overflow;
	assign symbol.word_last    = data_q.word_last;

endmodule
`default_nettype wire

// ===== hdl/morse_key_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder
// Decodes a sampled Morse key into dit/dah pattern indices, one per letter.
//
// The sample channel takes one key level per transaction. The symbol channel
// returns one transaction per finished letter: the heap-style pattern index,
// an overflow flag for letters longer than MAX_ELEMENTS, and a word end flag
// when the letter was closed by a gap longer than seven units.
// cfg_we/cfg_data write the unit length in ticks; the dah and word limits
// (three and seven units) are precomputed in registers on the write.
// Throughput is one sample per cycle while the queue has room. A letter is
// pushed into the queue in the same cycle as the sample that closes it is accepted.
// Results pass through a two-entry queue and an output register. When the
// receiver stalls, the queue fills and sample.ready drops until an entry
// frees up; no sample is taken without room for its result.
// Reset empties the queue and output, returns the decoder to idle and sets
// the unit length to 100 ticks.
// ----------------------------------------------------------------------------
module morse_key_decoder_top import mkd_pkg::*; #(
	parameter int MAX_ELEMENTS = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [UnitW-1:0] cfg_data,
	mkd_sample_if.sink            sample,
	mkd_symbol_if.source          symbol
);

	logic          push, pop;
	sym_t          push_data, pop_data;
	queue_status_t q_status;

	mkd_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.sample   (sample),
		.q_full   (q_status.full),
		.push     (push),
		.push_data(push_data)
	);

	mkd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (q_status)
	);

	mkd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_status(q_status),
		.q_data  (pop_data),
		.pop     (pop),
		.symbol  (symbol)
	);

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (sample.valid && sample.ready && !q_status.full))
		else $error("result pushed without an accepted sample");

	a_push_has_element: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.symbol_index >= PatW'(2)))
		else $error("finished letter without any element");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("result queue both full and empty");

endmodule
`default_nettype wire

// ===== tb/morse_key_decoder_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder testbench
// Feeds key samples through the sample channel and checks every decoded
// letter on the symbol channel against a cycle-free model of the decoder.
// Directed tests cover the default unit, unit boundaries, overflow, the zero
// unit and back-pressure; random letters follow under varying idling.
// ----------------------------------------------------------------------------
module morse_key_decoder_top_tb;
	import mkd_pkg::*;

	localparam int MaxElements = 6;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [UnitW-1:0] cfg_data;

	mkd_sample_if sample_ch();
	mkd_symbol_if symbol_ch();

	morse_key_decoder_top #(
		.MAX_ELEMENTS(MaxElements)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.sample  (sample_ch),
		.symbol  (symbol_ch)
	);

	phase_t           key_phase;
	logic [CountW-1:0] tick_run;
	logic [PatW-1:0]  letter_pat;
	logic             letter_long;
	logic [UnitW-1:0] unit_len;

	sym_t pending_symbols[$];
	int   errors;
	int   samples_sent;
	int   symbols_predicted;
	int   send_idle_pct;
	int   rcv_idle_pct;
	int   stall_left;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void start_letter();
		letter_pat  = PatStart;
		letter_long = 1'b0;
		key_phase   = PH_DOWN;
		tick_run    = CountW'(1);
	endfunction

	function automatic void add_element(bit dah);
		if (letter_pat >= PatW'(1 << MaxElements)) begin
			letter_long = 1'b1;
		end else begin
			letter_pat = {letter_pat[PatW-2:0], dah};
		end
	endfunction

	function automatic void push_symbol(bit word);
		sym_t s;
		s.symbol_index = letter_pat;
		s.overflow     = letter_long;
		s.word_last    = word;
		pending_symbols.push_back(s);
		symbols_predicted++;
	endfunction

	function automatic void decode_key(bit key);
		int dah_limit;
		int word_limit;
		dah_limit  = DahMult * int'(unit_len);
		word_limit = WordMult * int'(unit_len);
		case (key_phase)
			PH_DOWN: begin
				if (key) begin
					if (tick_run != CountMax) tick_run++;
				end else begin
					add_element(int'(tick_run) > dah_limit);
					key_phase = PH_UP;
					tick_run  = CountW'(1);
				end
			end
			PH_UP: begin
				if (!key) begin
					if (tick_run != CountMax) tick_run++;
					if (int'(tick_run) > word_limit) begin
						push_symbol(1'b1);
						key_phase   = PH_IDLE;
						tick_run    = '0;
						letter_pat  = PatStart;
						letter_long = 1'b0;
					end
				end else if (int'(tick_run) > dah_limit) begin
					push_symbol(1'b0);
					start_letter();
				end else begin
					key_phase = PH_DOWN;
					tick_run  = CountW'(1);
				end
			end
			default: begin
				if (key) begin
					start_letter();
				end else begin
					key_phase = PH_IDLE;
					tick_run  = '0;
				end
			end
		endcase
	endfunction

	task automatic send_sample(input bit key);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid    <= 1'b0;
			sample_ch.key_down <= 1'($urandom);
			@(negedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.key_down <= key;
		do @(posedge clk); while (!sample_ch.ready);
		decode_key(key);
		samples_sent++;
	endtask

	task automatic key_run(input bit level, input int n);
		repeat (n) send_sample(level);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_symbols.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_unit(input int unsigned value);
		wait_idle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= UnitW'(value);
		@(negedge clk);
		cfg_we   <= 1'b0;
		unit_len = UnitW'(value);
	endtask

	task automatic send_letter(input int unsigned u);
		int elems;
		if ($urandom_range(99) < 80) begin
			elems = $urandom_range(1, MaxElements);
		end else begin
			elems = $urandom_range(MaxElements + 1, MaxElements + 2);
		end
		for (int i = 0; i < elems; i++) begin
			key_run(1'b1, $urandom_range(1, 3 * u + 2));
			if (i != elems - 1) key_run(1'b0, $urandom_range(1, 3 * u));
		end
		if ($urandom_range(1) == 1) begin
			key_run(1'b0, $urandom_range(3 * u + 1, 7 * u));
		end else begin
			key_run(1'b0, $urandom_range(7 * u + 1, 7 * u + 3));
		end
	endtask

	task automatic test_default_unit();
		key_run(1'b0, 3);
		key_run(1'b1, 301);
		key_run(1'b0, 2);
	endtask

	task automatic test_element_timing();
		write_unit(1);
		key_run(1'b1, 3);
		key_run(1'b0, 3);
		key_run(1'b1, 4);
		key_run(1'b0, 4);
		key_run(1'b1, 1);
		key_run(1'b0, 7);
		key_run(1'b0, 1);
	endtask

	task automatic test_overflow();
		write_unit(1);
		repeat (MaxElements) begin
			key_run(1'b1, 4);
			key_run(1'b0, 1);
		end
		key_run(1'b0, 8);
		repeat (MaxElements) begin
			key_run(1'b1, 1);
			key_run(1'b0, 1);
		end
		key_run(1'b0, 4);
		key_run(1'b1, 1);
		key_run(1'b0, 8);
		repeat (MaxElements + 2) begin
			key_run(1'b1, $urandom_range(1, 4));
			key_run(1'b0, 1);
		end
		key_run(1'b0, 8);
	endtask

	task automatic test_zero_unit();
		write_unit(0);
		key_run(1'b1, 1);
		key_run(1'b0, 1);
		key_run(1'b1, 1);
		key_run(1'b0, 2);
		key_run(1'b1, 3);
		key_run(1'b0, 2);
	endtask

	task automatic test_backpressure();
		write_unit(0);
		stall_left = 200;
		repeat (40) begin
			send_sample(1'b1);
			send_sample(1'b0);
			send_sample(1'($urandom));
		end
		key_run(1'b0, 2);
	endtask

	task automatic test_random_letters(input int items, input int min_syms);
		int          first_item;
		int          first_sym;
		int unsigned u;
		first_item = samples_sent;
		first_sym  = symbols_predicted;
		while (samples_sent - first_item < items || symbols_predicted - first_sym < min_syms) begin
			u = $urandom_range(1, 4);
			write_unit(u);
			repeat (2) begin
				if ($urandom_range(99) < 85) begin
					send_letter(u);
				end else begin
					repeat ($urandom_range(1, 12)) send_sample(1'($urandom));
				end
			end
			key_run(1'b0, 7 * u + 2);
		end
	endtask

	initial begin
		symbol_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				symbol_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				symbol_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		sym_t want;
		if (arst_n && symbol_ch.valid && symbol_ch.ready) begin
			if (pending_symbols.size() == 0) begin
				errors++;
				$display("%0t: unexpected symbol, expected none, actual %0d/%0b/%0b", $time,
					symbol_ch.symbol_index, symbol_ch.overflow, symbol_ch.word_last);
			end else begin
				want = pending_symbols.pop_front();
				if (symbol_ch.symbol_index !== want.symbol_index) begin
					errors++;
					$display("%0t: symbol_index expected %0d actual %0d", $time,
						want.symbol_index, symbol_ch.symbol_index);
				end
				if (symbol_ch.overflow !== want.overflow) begin
					errors++;
					$display("%0t: overflow expected %0b actual %0b", $time,
						want.overflow, symbol_ch.overflow);
				end
				if (symbol_ch.word_last !== want.word_last) begin
					errors++;
					$display("%0t: word_last expected %0b actual %0b", $time,
						want.word_last, symbol_ch.word_last);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_data           = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.key_down = 1'b0;
		errors             = 0;
		samples_sent       = 0;
		symbols_predicted  = 0;
		stall_left         = 0;
		send_idle_pct      = 16;
		rcv_idle_pct       = 77;
		key_phase          = PH_IDLE;
		tick_run           = '0;
		letter_pat         = PatStart;
		letter_long        = 1'b0;
		unit_len           = UnitW'(UnitReset);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_unit();
		test_element_timing();
		test_overflow();
		test_zero_unit();
		test_random_letters(70, 4);

		send_idle_pct = 77;
		rcv_idle_pct  = 16;
		test_random_letters(70, 4);

		send_idle_pct = 0;
		rcv_idle_pct  = 0;
		test_backpressure();
		test_random_letters(70, 4);

		wait_idle();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/mkd_pkg.sv
hdl/mkd_ifs.sv
hdl/mkd_front.sv
hdl/mkd_queue.sv
hdl/mkd_back.sv
hdl/morse_key_decoder_top.sv
tb/morse_key_decoder_top_tb.sv
